[hdl/ihdp_pkg.sv]
package ihdp_pkg;

   localparam logic [1:0] FMT_PNG  = 2'd0;
   localparam logic [1:0] FMT_JPEG = 2'd1;
   localparam logic [1:0] FMT_PPM  = 2'd2;

   localparam logic [7:0] JPG_MARKER_LEAD = 8'hFF;
   localparam logic [7:0] JPG_SOF0        = 8'hC0;
   localparam logic [7:0] JPG_SOF2        = 8'hC2;
   localparam logic [7:0] JPG_SOI         = 8'hD8;
   localparam logic [7:0] PPM_CHAR_P      = 8'h50;
   localparam logic [7:0] PPM_CHAR_6      = 8'h36;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_IHDR   = 3'd1,
      ST_NO_SOF    = 3'd2,
      ST_SHORT     = 3'd3,
      ST_BAD_MAGIC = 3'd4
   } status_type;

   // JPEG and PPM phases share the start phase; a format write clears the phase
   typedef enum logic [3:0] {
      PH_START,
      PH_JMARK,
      PH_JLEN_HI,
      PH_JLEN_LO,
      PH_JSKIP,
      PH_JSOF,
      PH_JBAD,
      PH_PMAGIC,
      PH_PWS1,
      PH_PWIDTH,
      PH_PWS2,
      PH_PHEIGHT
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [31:0] image_width;
      logic [31:0] image_height;
      status_type  parse_status;
   } result_type;

   function automatic logic [7:0] ihdr_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0: c = 8'h49;
         2'd1: c = 8'h48;
         2'd2: c = 8'h44;
         default: c = 8'h52;
      endcase
      return c;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction

   // acc * 10 + digit, saturating at all ones
   function automatic logic [31:0] dec_acc(input logic [31:0] acc, input logic [7:0] b);
      logic [35:0] v;
      v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {32'b0, b[3:0]};
      return (v[35:32] != 4'b0) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

endpackage

[hdl/ihdp_parse.sv]
module ihdp_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cfg_wr,
   input  logic [1:0]           cfg_format,
   input  logic                 step_en,
   input  ihdp_pkg::item_type   item,
   output ihdp_pkg::result_type result
);

   logic [1:0]          format_ff;
   ihdp_pkg::phase_type phase_ff, phase_in;
   logic [15:0]         cnt_ff, cnt_in;
   logic [31:0]         w_ff, w_in;
   logic [31:0]         h_ff, h_in;
   logic [7:0]          marker_ff, marker_in;
   logic                given_ff, given_in;

   always_comb begin
      logic [7:0]  b;
      logic [15:0] len;
      logic        emit;
      ihdp_pkg::status_type status;

      b          = item.data_byte;
      len        = {cnt_ff[15:8], b};
      emit       = 1'b0;
      status     = ihdp_pkg::ST_OK;
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      marker_in  = marker_ff;

      if (!given_ff) begin
         case (format_ff)
            ihdp_pkg::FMT_JPEG: begin
               case (phase_ff)
                  ihdp_pkg::PH_START: begin
                     phase_in = (b == ihdp_pkg::JPG_MARKER_LEAD) ?
                                ihdp_pkg::PH_JMARK : ihdp_pkg::PH_JBAD;
                  end
                  ihdp_pkg::PH_JMARK: begin
                     marker_in = b;
                     phase_in  = (b == ihdp_pkg::JPG_SOI) ?
                                 ihdp_pkg::PH_START : ihdp_pkg::PH_JLEN_HI;
                  end
                  ihdp_pkg::PH_JLEN_HI: begin
                     cnt_in   = {b, 8'h00};
                     phase_in = ihdp_pkg::PH_JLEN_LO;
                  end
                  ihdp_pkg::PH_JLEN_LO: begin
                     if (marker_ff == ihdp_pkg::JPG_SOF0 || marker_ff == ihdp_pkg::JPG_SOF2) begin
                        cnt_in   = '0;
                        phase_in = ihdp_pkg::PH_JSOF;
                     end else begin
                        cnt_in   = (len >= 16'd2) ? len - 16'd2 : '0;
                        phase_in = (len <= 16'd2) ? ihdp_pkg::PH_START : ihdp_pkg::PH_JSKIP;
                     end
                  end
                  ihdp_pkg::PH_JSKIP: begin
                     cnt_in = cnt_ff - 16'd1;
                     if (cnt_ff == 16'd1) begin
                        phase_in = ihdp_pkg::PH_START;
                     end
                  end
                  ihdp_pkg::PH_JSOF: begin
                     // SOF data: precision, height hi/lo, width hi/lo
                     if (cnt_ff == 16'd1 || cnt_ff == 16'd2) begin
                        h_in = {16'b0, h_ff[7:0], b};
                     end else if (cnt_ff == 16'd3 || cnt_ff == 16'd4) begin
                        w_in = {16'b0, w_ff[7:0], b};
                     end
                     if (cnt_ff >= 16'd4) begin
                        emit = 1'b1;
                     end else begin
                        cnt_in = cnt_ff + 16'd1;
                     end
                  end
                  default: begin
                     emit   = 1'b1;
                     status = ihdp_pkg::ST_NO_SOF;
                  end
               endcase
            end
            ihdp_pkg::FMT_PPM: begin
               case (phase_ff)
                  ihdp_pkg::PH_START: begin
                     if (!ihdp_pkg::is_space(b)) begin
                        if (b == ihdp_pkg::PPM_CHAR_P) begin
                           phase_in = ihdp_pkg::PH_PMAGIC;
                           cnt_in   = 16'd1;
                        end else begin
                           emit   = 1'b1;
                           status = ihdp_pkg::ST_BAD_MAGIC;
                        end
                     end
                  end
                  ihdp_pkg::PH_PMAGIC: begin
                     if (cnt_ff < 16'd2) begin
                        if (b == ihdp_pkg::PPM_CHAR_6) begin
                           cnt_in = 16'd2;
                        end else begin
                           emit   = 1'b1;
                           status = ihdp_pkg::ST_BAD_MAGIC;
                        end
                     end else if (ihdp_pkg::is_space(b)) begin
                        phase_in = ihdp_pkg::PH_PWS1;
                     end else begin
                        emit   = 1'b1;
                        status = ihdp_pkg::ST_BAD_MAGIC;
                     end
                  end
                  ihdp_pkg::PH_PWS1: begin
                     if (ihdp_pkg::is_digit(b)) begin
                        w_in     = ihdp_pkg::dec_acc(32'd0, b);
                        phase_in = ihdp_pkg::PH_PWIDTH;
                     end else if (!ihdp_pkg::is_space(b)) begin
                        emit = 1'b1;
                     end
                  end
                  ihdp_pkg::PH_PWIDTH: begin
                     if (ihdp_pkg::is_digit(b)) begin
                        w_in = ihdp_pkg::dec_acc(w_ff, b);
                     end else if (ihdp_pkg::is_space(b)) begin
                        phase_in = ihdp_pkg::PH_PWS2;
                     end else begin
                        emit = 1'b1;
                     end
                  end
                  ihdp_pkg::PH_PWS2: begin
                     if (ihdp_pkg::is_digit(b)) begin
                        h_in     = ihdp_pkg::dec_acc(32'd0, b);
                        phase_in = ihdp_pkg::PH_PHEIGHT;
                     end else if (!ihdp_pkg::is_space(b)) begin
                        emit = 1'b1;
                     end
                  end
                  default: begin
                     if (ihdp_pkg::is_digit(b)) begin
                        h_in = ihdp_pkg::dec_acc(h_ff, b);
                     end else begin
                        emit = 1'b1;
                     end
                  end
               endcase
            end
            default: begin
               // PNG, also for the unused format code
               if (cnt_ff >= 16'd12 && cnt_ff <= 16'd15 &&
                   b != ihdp_pkg::ihdr_char(cnt_ff[1:0])) begin
                  emit   = 1'b1;
                  status = ihdp_pkg::ST_NO_IHDR;
               end else if (cnt_ff == 16'd28) begin
                  emit = 1'b1;
               end else begin
                  if (cnt_ff >= 16'd16 && cnt_ff <= 16'd19) begin
                     w_in = {w_ff[23:0], b};
                  end else if (cnt_ff >= 16'd20 && cnt_ff <= 16'd23) begin
                     h_in = {h_ff[23:0], b};
                  end
                  if (cnt_ff != 16'hFFFF) begin
                     cnt_in = cnt_ff + 16'd1;
                  end
               end
            end
         endcase
      end

      given_in = given_ff | emit;

      // end mark forces a result if none was given for this file
      if (item.end_of_file && !given_in) begin
         emit = 1'b1;
         if (format_ff == ihdp_pkg::FMT_PPM) begin
            if (phase_in == ihdp_pkg::PH_START ||
                (phase_in == ihdp_pkg::PH_PMAGIC && cnt_in < 16'd2)) begin
               status = ihdp_pkg::ST_BAD_MAGIC;
            end else if (phase_in == ihdp_pkg::PH_PHEIGHT) begin
               status = ihdp_pkg::ST_OK;
            end else begin
               status = ihdp_pkg::ST_SHORT;
            end
         end else begin
            status = ihdp_pkg::ST_SHORT;
         end
      end

      result.valid        = step_en & emit;
      result.image_width  = (status == ihdp_pkg::ST_OK) ? w_in : 32'd0;
      result.image_height = (status == ihdp_pkg::ST_OK) ? h_in : 32'd0;
      result.parse_status = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_ff <= ihdp_pkg::FMT_PNG;
      end else if (cfg_wr) begin
         format_ff <= cfg_format;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_wr || (step_en && item.end_of_file)) begin
         phase_ff  <= ihdp_pkg::PH_START;
         cnt_ff    <= '0;
         w_ff      <= '0;
         h_ff      <= '0;
         marker_ff <= '0;
         given_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         w_ff      <= w_in;
         h_ff      <= h_in;
         marker_ff <= marker_in;
         given_ff  <= given_in;
      end
   end

endmodule

[hdl/image_header_dimension_parser.sv]
// Image header dimension parser.
// req_*: one file byte per item (tdata), tlast on the final byte of the file.
// rsp_*: one item per file with width, height and status; zero dimensions
//   unless the status is ok. Status: 0 ok, 1 missing IHDR, 2 SOF not found,
//   3 unexpected end, 4 bad PPM magic.
// csr_*: format register, 0 PNG, 1 JPEG, 2 binary PPM (3 acts as PNG).
//   A write restarts the parse of the current file; write only while idle.
// Throughput: one byte per cycle unless a pending result stalls on rsp_tready.
//   The per-byte state update is a single combinational step between the input
//   register and the result register. The byte that causes a result passes
//   the input register, then the result register, which drives rsp_tvalid.
// Bytes after a result are consumed and dropped up to the end mark.
// When rsp_tready is low with a result pending, the result register holds
//   and one more byte may wait in the input register; further bytes stall.
// Reset (synchronous) empties both registers, sets the format to PNG and
//   clears the parse state; no clearing pass is needed.
module image_header_dimension_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] image_width, [63:32] image_height,
                                    // [66:64] parse_status, [71:67] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data     // file format code
);

   logic                 in_valid_ff;
   ihdp_pkg::item_type   in_item_ff;
   logic                 out_valid_ff;
   ihdp_pkg::result_type out_res_ff;
   ihdp_pkg::result_type step_res;
   logic                 advance;
   logic                 cfg_wr;

   assign csr_ready  = 1'b1;
   assign cfg_wr     = csr_valid & csr_ready;
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;

   ihdp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .cfg_wr     (cfg_wr),
      .cfg_format (csr_data),
      .step_en    (advance),
      .item       (in_item_ff),
      .result     (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.data_byte   <= req_tdata;
         in_item_ff.end_of_file <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_res.valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_res.valid) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_res_ff.parse_status, out_res_ff.image_height,
                        out_res_ff.image_width};

   a_zero_dims_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_res_ff.parse_status != ihdp_pkg::ST_OK |->
         out_res_ff.image_width == 32'd0 && out_res_ff.image_height == 32'd0)
      else $error("nonzero dimensions with error status");

   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(in_valid_ff))
      else $error("result without a processed item");

   a_stalled_item_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled item lost");

endmodule
